// ===== design/npu_pkg.sv =====
// Shared types and constants for the nibble pixel unpacker.
// Used by npu_pixbuf and nibble_pixel_unpacker; no dependencies.
package npu_pkg;

    localparam int MAX_PIX = 3;
    localparam int CNT_W   = $clog2(MAX_PIX + 1);

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic       bitmap_last;
        logic       run_last;
        logic [7:0] index;
    } t_pix;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ROW_WIDTH    = 3'd0;
    localparam t_cfg_idx CFG_ROW_COUNT    = 3'd1;
    localparam t_cfg_idx CFG_PALETTE_BASE = 3'd2;
    localparam t_cfg_idx CFG_TRANSPARENT  = 3'd3;
    localparam t_cfg_idx CFG_PAD_ENABLE   = 3'd4;
    localparam t_cfg_idx CFG_BLANK_LAST   = 3'd5;

    localparam int         PAD_COLS    = 4;
    localparam logic [7:0] ZERO_TRANSP = 8'hFF;
    localparam logic [7:0] ZERO_OPAQUE = 8'h00;

endpackage

// ===== design/npu_pixbuf.sv =====
// Result buffer: holds up to three pixels from one byte and hands them out
// one per cycle while i_pop is high. Depends on npu_pkg.
module npu_pixbuf (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  npu_pkg::t_pix [npu_pkg::MAX_PIX-1:0] i_pix,
    input  npu_pkg::t_cnt                       i_cnt,
    input  logic                                i_pop,
    output npu_pkg::t_pix                       o_head,
    output logic                                o_valid,
    output npu_pkg::t_cnt                       o_cnt
);

    npu_pkg::t_pix [npu_pkg::MAX_PIX-1:0] r_slot;
    npu_pkg::t_cnt                        r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (i_pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_pix;
        end else if (i_pop) begin
            for (int k = 0; k < npu_pkg::MAX_PIX - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

    assign o_head  = r_slot[0];
    assign o_valid = (r_cnt != '0);
    assign o_cnt   = r_cnt;

endmodule

// ===== design/nibble_pixel_unpacker.sv =====
// Top level of the nibble pixel unpacker: config registers, byte input
// register, column/row tracking and pixel expansion.
// Depends on npu_pkg and npu_pixbuf.
//
// Usage:
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   one register per request; a write to a known index also rewinds the
//   bitmap position to row 0, column 0. Write only while the block is idle.
//   The slave stream takes packed bytes (high nibble = even column); the
//   master stream gives one 8-bit palette index per request, with tlast on
//   the last pixel of each byte and tuser on the final pixel of the bitmap.
//   A byte accepted into the input register moves on to the pixel buffer,
//   whose head drives the master stream. Throughput: the master side moves
//   one pixel per cycle while m_axis_tready is high; a byte yields two
//   pixels normally, one or three at row edges, or none.
//   The input register takes the next byte while pixels still drain.
//   Reset restores the default registers and the start position.
//   When the receiver stalls, the pixel buffer holds, then the input
//   register fills and s_axis_tready drops. Bytes after the end of the
//   bitmap are consumed and yield nothing.
module nibble_pixel_unpacker #(
    parameter  int DIM_BITS = 10,
    localparam int CFG_W    = (DIM_BITS > 8) ? DIM_BITS : 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  npu_pkg::t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] packed_byte
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] pixel_index
    output logic                      m_axis_tlast,   // run_last
    output logic                      m_axis_tuser    // [0] bitmap_last
);

    localparam int COL_W = DIM_BITS + 1;

    logic [DIM_BITS-1:0] r_row_width;
    logic [DIM_BITS-1:0] r_row_count;
    logic [7:0]          r_base;
    logic                r_transp;
    logic                r_pad;
    logic                r_blank;

    logic [COL_W-1:0]    r_col;
    logic [DIM_BITS-1:0] r_row;
    logic                r_fin;

    logic                r_byte_vld;
    logic [7:0]          r_byte;

    logic [COL_W-1:0]    n_col;
    logic [DIM_BITS-1:0] n_row;
    logic                n_fin;
    npu_pkg::t_pix [npu_pkg::MAX_PIX-1:0] n_pix;
    npu_pkg::t_cnt       n_cnt;

    logic [COL_W-1:0]    w_vis;
    logic [COL_W-1:0]    w_total;
    logic [7:0]          w_zero;
    logic                w_act;
    logic                w_odd;
    logic [3:0]          w_nib;
    logic                w_cfg_we;
    logic                w_cfg_known;
    logic                w_load;
    logic                w_pop;
    npu_pkg::t_pix       w_head;
    npu_pkg::t_cnt       w_cnt;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        unique case (i_cfg_index)
            npu_pkg::CFG_ROW_WIDTH,
            npu_pkg::CFG_ROW_COUNT,
            npu_pkg::CFG_PALETTE_BASE,
            npu_pkg::CFG_TRANSPARENT,
            npu_pkg::CFG_PAD_ENABLE,
            npu_pkg::CFG_BLANK_LAST: w_cfg_known = 1'b1;
            default:                 w_cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= DIM_BITS'(8);
            r_row_count <= DIM_BITS'(8);
            r_base      <= '0;
            r_transp    <= 1'b0;
            r_pad       <= 1'b0;
            r_blank     <= 1'b0;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                npu_pkg::CFG_ROW_WIDTH:    r_row_width <= i_cfg_data[DIM_BITS-1:0];
                npu_pkg::CFG_ROW_COUNT:    r_row_count <= i_cfg_data[DIM_BITS-1:0];
                npu_pkg::CFG_PALETTE_BASE: r_base      <= i_cfg_data[7:0];
                npu_pkg::CFG_TRANSPARENT:  r_transp    <= i_cfg_data[0];
                npu_pkg::CFG_PAD_ENABLE:   r_pad       <= i_cfg_data[0];
                npu_pkg::CFG_BLANK_LAST:   r_blank     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // row geometry; narrow rows count as two columns
    assign w_vis   = (r_row_width < DIM_BITS'(2)) ? COL_W'(2) : {1'b0, r_row_width};
    assign w_total = w_vis + (r_pad ? COL_W'(npu_pkg::PAD_COLS) : COL_W'(0));
    assign w_zero  = r_transp ? npu_pkg::ZERO_TRANSP : npu_pkg::ZERO_OPAQUE;

    // walk the columns covered by the pending byte; stops after an odd column or at the end of the bitmap
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_fin = r_fin;
        n_cnt = '0;
        n_pix = '0;
        w_odd = 1'b0;
        w_nib = '0;
        w_act = !r_fin && (r_row_count != '0);
        for (int k = 0; k < npu_pkg::MAX_PIX; k++) begin
            if (w_act) begin
                w_odd = n_col[0];
                w_nib = w_odd ? r_byte[3:0] : r_byte[7:4];
                if (r_blank && (n_col == w_total - 1'b1)) begin
                    w_nib = '0;
                end
                if (!r_pad || (n_col < w_vis)) begin
                    n_pix[n_cnt].index       = (w_nib != '0) ? (r_base + {4'b0000, w_nib})
                                                             : w_zero;
                    n_pix[n_cnt].run_last    = 1'b0;
                    n_pix[n_cnt].bitmap_last =
                        (({1'b0, n_row} + 1'b1) == {1'b0, r_row_count}) &&
                        (n_col == w_vis - 1'b1);
                    n_cnt = n_cnt + 1'b1;
                end
                n_col = n_col + 1'b1;
                if (n_col >= w_total) begin
                    n_col = '0;
                    n_row = n_row + 1'b1;
                    if (n_row >= r_row_count) begin
                        n_fin = 1'b1;
                        w_act = 1'b0;
                    end
                end
                if (w_odd) begin
                    w_act = 1'b0;
                end
            end
        end
        if (n_cnt != '0) begin
            n_pix[n_cnt - 1'b1].run_last = 1'b1;
        end
    end

    assign w_pop  = m_axis_tvalid && m_axis_tready;
    assign w_load = r_byte_vld &&
                    ((w_cnt == '0) || ((w_cnt == npu_pkg::t_cnt'(1)) && w_pop));
    assign s_axis_tready = !r_byte_vld || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_byte_vld <= 1'b1;
        end else if (w_load) begin
            r_byte_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_fin <= 1'b0;
        end else if (w_cfg_we && w_cfg_known) begin
            r_col <= '0;
            r_row <= '0;
            r_fin <= 1'b0;
        end else if (w_load) begin
            r_col <= n_col;
            r_row <= n_row;
            r_fin <= n_fin;
        end
    end

    npu_pixbuf u_pixbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_pix   (n_pix),
        .i_cnt   (n_cnt),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_valid (m_axis_tvalid),
        .o_cnt   (w_cnt)
    );

    assign m_axis_tdata = w_head.index;
    assign m_axis_tlast = w_head.run_last;
    assign m_axis_tuser = w_head.bitmap_last;

`ifndef SYNTHESIS
    a_single_left_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_cnt == npu_pkg::t_cnt'(1))) |-> m_axis_tlast)
        else $error("last buffered pixel lacks tlast");

    a_bitmap_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("bitmap end pixel is not last of its byte");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < w_total)
        else $error("column position beyond padded row");

    a_fin_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_col == '0))
        else $error("finished with nonzero column");
`endif

endmodule
